// ----- rtl/core/bfx3_pkg.sv -----
`timescale 1ns / 1ps
// constants, register codes and shared types of the 3x3 mean box filter
// no dependencies; used by the channel interfaces and the top level

package bfx3_pkg;

    // fixed widths of the stream fields and configuration registers
    localparam int PIX_W        = 16;
    localparam int DIM_W        = 12;
    localparam int ROW_W        = 11;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // image size limits and reset values
    localparam int MIN_DIM      = 3;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int PIXEL_BITS_DEF = 16;

    // divide by 9 as multiply by reciprocal: exact for any sum below 2^20
    localparam int DIV9_MUL_W = 20;
    localparam int DIV9_MUL   = 932068;
    localparam int DIV9_SHIFT = 23;

    // register index, taken from the word address
    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    // position of a pixel in the frame, resolved when it is accepted
    typedef struct packed
    {
        logic row_ok;    // row >= 1
        logic col_ok;    // column >= 1
        logic interior;  // row >= 2 and column >= 2
        logic last_row;
        logic last_col;
    } pos_flags_t;

endpackage

// ----- rtl/core/bfx3_if.sv -----
`timescale 1ns / 1ps
// valid/ready stream interfaces for pixels into and out of the box filter
// depends on bfx3_pkg

interface bfx3_pix_in_if;
    logic                       valid;
    logic                       ready;
    logic [bfx3_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bfx3_pix_out_if;
    logic                       valid;
    logic                       ready;
    logic [bfx3_pkg::PIX_W-1:0] pixel_out;
    logic                       image_done;

    modport source (output valid, output pixel_out, output image_done, input ready);
    modport sink   (input valid, input pixel_out, input image_done, output ready);
endinterface

// ----- rtl/core/box_filter_3x3.sv -----
`timescale 1ns / 1ps
// 3x3 mean box filter over a raster-order grayscale pixel stream
// depends on bfx3_pkg and the stream interfaces in bfx3_if.sv

// Takes one pixel per beat in raster order and returns the filtered image in
// raster order, about one row behind the input. Interior pixels are the
// truncated mean of their 3x3 neighbourhood of original input pixels; pixels
// on the first and last row and column pass through unchanged. Width and
// height come from two APB registers (word 0 width, word 1 height, clamped to
// 3..MAX_WIDTH and 3..2048) and may only be changed while the filter is idle.
// Rate: one pixel per clock within a row while the output is ready. Each beat
// reads its column from the two row memories at accept and writes it back when
// it leaves the first stage; a result then passes stages 2 and 3 and the output
// buffer on its way to the output. The single output port sets the rate
// wherever a pixel yields more than one result: the last pixel of every row but
// the first yields two, which stalls the input once per row; on the last row
// every pixel past the first column yields two results, so the input stalls
// between its pixels there, and the final pixel yields four results, the last
// one flagged with image_done. The row memories need no clearing pass after
// reset; an entry that is read before it is written only feeds window sums and
// pass-through candidates that are never selected for output.
module box_filter_3x3 #(
    parameter int MAX_WIDTH  = bfx3_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = bfx3_pkg::PIXEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bfx3_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bfx3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bfx3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,

    bfx3_pix_in_if.sink                         in_ch,
    bfx3_pix_out_if.source                      out_ch
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CMP_W  = (COL_W + 1 > bfx3_pkg::DIM_W) ? COL_W + 1 : bfx3_pkg::DIM_W;
    localparam int CS_W   = PIXEL_BITS + 2;    // sum of one window column
    localparam int SUM_W  = PIXEL_BITS + 4;    // sum of the whole window
    localparam int PROD_W = SUM_W + bfx3_pkg::DIV9_MUL_W;
    localparam int ROW_W  = bfx3_pkg::ROW_W;
    localparam int DIM_W  = bfx3_pkg::DIM_W;

    // pass-through candidates of one window position
    typedef struct packed
    {
        logic [PIXEL_BITS-1:0] mid_prev;   // middle row, previous column
        logic [PIXEL_BITS-1:0] bot_prev;   // bottom row, previous column
        logic [PIXEL_BITS-1:0] mid_cur;    // middle row, current column
        logic [PIXEL_BITS-1:0] bot_cur;    // bottom row, current column
    } pass_vals_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             cfg_write;
    bfx3_pkg::reg_idx_t cfg_idx;

    assign cfg_idx   = bfx3_pkg::reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(bfx3_pkg::WIDTH_RESET);
            height_reg <= DIM_W'(bfx3_pkg::HEIGHT_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                bfx3_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                bfx3_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            bfx3_pkg::REG_IMAGE_WIDTH:  prdata = bfx3_pkg::APB_DATA_W'(width_reg);
            bfx3_pkg::REG_IMAGE_HEIGHT: prdata = bfx3_pkg::APB_DATA_W'(height_reg);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // frame geometry: clamp the size, find the last column and row
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] width_clamp;
    logic [DIM_W-1:0] height_clamp;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;

    assign width_ext = CMP_W'(width_reg);

    always_comb
    begin
        if (width_ext < CMP_W'(bfx3_pkg::MIN_DIM))
            width_clamp = CMP_W'(bfx3_pkg::MIN_DIM);
        else if (width_ext > CMP_W'(MAX_WIDTH))
            width_clamp = CMP_W'(MAX_WIDTH);
        else
            width_clamp = width_ext;

        if (height_reg < DIM_W'(bfx3_pkg::MIN_DIM))
            height_clamp = DIM_W'(bfx3_pkg::MIN_DIM);
        else if (height_reg > DIM_W'(bfx3_pkg::HEIGHT_LIMIT))
            height_clamp = DIM_W'(bfx3_pkg::HEIGHT_LIMIT);
        else
            height_clamp = height_reg;
    end

    assign col_last = COL_W'(width_clamp - CMP_W'(1));
    assign row_last = ROW_W'(height_clamp - DIM_W'(1));

    // ------------------------------------------------------------------
    // pipeline handshake
    // ------------------------------------------------------------------
    logic in_fire;
    logic s1_valid_reg, s1_fire;
    logic s2_valid_reg, s2_fire;
    logic s3_valid_reg, s3_fire;
    logic buf_free;

    assign s3_fire      = s3_valid_reg && buf_free;
    assign s2_fire      = s2_valid_reg && (!s3_valid_reg || s3_fire);
    assign s1_fire      = s1_valid_reg && (!s2_valid_reg || s2_fire);
    assign in_ch.ready  = !s1_valid_reg || s1_fire;
    assign in_fire      = in_ch.valid && in_ch.ready;

    // ------------------------------------------------------------------
    // raster position of the incoming beat
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0] col_acc;
    logic [ROW_W-1:0] row_acc;
    bfx3_pkg::pos_flags_t flags_acc;

    // a count at or past the last position counts as the last position
    assign col_acc = (col_count_reg >= col_last) ? col_last : col_count_reg;
    assign row_acc = (row_count_reg >= row_last) ? row_last : row_count_reg;

    always_comb
    begin
        flags_acc.row_ok   = (row_acc != '0);
        flags_acc.col_ok   = (col_acc != '0);
        flags_acc.interior = (row_acc >= ROW_W'(2)) && (col_acc >= COL_W'(2));
        flags_acc.last_row = (row_acc == row_last);
        flags_acc.last_col = (col_acc == col_last);

        if (flags_acc.last_col)
        begin
            col_count_next = '0;
            row_count_next = flags_acc.last_row ? '0 : row_acc + ROW_W'(1);
        end
        else
        begin
            col_count_next = col_acc + COL_W'(1);
            row_count_next = row_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (in_fire)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // row memories: upper holds row r-2, lower holds row r-1
    // read at accept, written back when the beat leaves stage 1; two
    // neighbouring beats never share a column since the width is at least 3
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_upper_reg;
    logic [PIXEL_BITS-1:0] rd_lower_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [COL_W-1:0]      s1_col_reg;
    bfx3_pkg::pos_flags_t  s1_flags_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_upper_reg <= upper_mem[col_acc];
            rd_lower_reg <= lower_mem[col_acc];
            s1_pix_reg   <= in_ch.pixel_in[PIXEL_BITS-1:0];
            s1_col_reg   <= col_acc;
            s1_flags_reg <= flags_acc;
        end
        if (s1_fire)
        begin
            upper_mem[s1_col_reg] <= rd_lower_reg;
            lower_mem[s1_col_reg] <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: slide the window; the window is kept as two column sums
    // plus the middle and bottom pixels of its newest column
    // ------------------------------------------------------------------
    logic [CS_W-1:0]       cs_mid_reg;     // sum of window column 0
    logic [CS_W-1:0]       cs_new_reg;     // sum of window column 1
    logic [PIXEL_BITS-1:0] mid_reg;
    logic [PIXEL_BITS-1:0] bot_reg;
    logic [CS_W-1:0]       cs_in;

    assign cs_in = CS_W'(rd_upper_reg) + CS_W'(rd_lower_reg) + CS_W'(s1_pix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_mid_reg <= '0;
            cs_new_reg <= '0;
            mid_reg    <= '0;
            bot_reg    <= '0;
        end
        else if (s1_fire)
        begin
            cs_mid_reg <= cs_new_reg;
            cs_new_reg <= cs_in;
            mid_reg    <= rd_lower_reg;
            bot_reg    <= s1_pix_reg;
        end
    end

    logic [CS_W-1:0]      s2_cs0_reg, s2_cs1_reg, s2_cs2_reg;
    pass_vals_t           s2_pass_reg;
    bfx3_pkg::pos_flags_t s2_flags_reg;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_cs0_reg            <= cs_mid_reg;
            s2_cs1_reg            <= cs_new_reg;
            s2_cs2_reg            <= cs_in;
            s2_pass_reg.mid_prev  <= mid_reg;
            s2_pass_reg.bot_prev  <= bot_reg;
            s2_pass_reg.mid_cur   <= rd_lower_reg;
            s2_pass_reg.bot_cur   <= s1_pix_reg;
            s2_flags_reg          <= s1_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: window sum
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]     s3_sum_reg;
    pass_vals_t           s3_pass_reg;
    bfx3_pkg::pos_flags_t s3_flags_reg;

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            s3_sum_reg   <= SUM_W'(s2_cs0_reg) + SUM_W'(s2_cs1_reg) + SUM_W'(s2_cs2_reg);
            s3_pass_reg  <= s2_pass_reg;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: divide by 9 and build the list of results for this beat
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]     mean_prod;
    logic [PIXEL_BITS-1:0] mean;
    logic [PIXEL_BITS-1:0] vals [4];
    logic [2:0]            n_vals;

    assign mean_prod = PROD_W'(s3_sum_reg) * PROD_W'(bfx3_pkg::DIV9_MUL);
    assign mean      = mean_prod[bfx3_pkg::DIV9_SHIFT +: PIXEL_BITS];

    // on the last row each result of row H-2 is followed by row H-1, same column
    always_comb
    begin
        n_vals = '0;
        for (int i = 0; i < 4; i++)
            vals[i] = '0;

        if (s3_flags_reg.row_ok && s3_flags_reg.col_ok)
        begin
            vals[n_vals[1:0]] = s3_flags_reg.interior ? mean : s3_pass_reg.mid_prev;
            n_vals = n_vals + 3'd1;
            if (s3_flags_reg.last_row)
            begin
                vals[n_vals[1:0]] = s3_pass_reg.bot_prev;
                n_vals = n_vals + 3'd1;
            end
        end
        if (s3_flags_reg.row_ok && s3_flags_reg.last_col)
        begin
            vals[n_vals[1:0]] = s3_pass_reg.mid_cur;
            n_vals = n_vals + 3'd1;
            if (s3_flags_reg.last_row)
            begin
                vals[n_vals[1:0]] = s3_pass_reg.bot_cur;
                n_vals = n_vals + 3'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage valids
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (!s2_valid_reg || s2_fire)
                s2_valid_reg <= s1_fire;
            if (!s3_valid_reg || s3_fire)
                s3_valid_reg <= s2_fire;
        end
    end

    // ------------------------------------------------------------------
    // output buffer: up to four results of one beat, sent while the output is ready, one a cycle
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] res_reg [4];
    logic [2:0]            res_cnt_reg, res_cnt_next;
    logic [1:0]            res_idx_reg, res_idx_next;
    logic                  res_done_reg;
    logic                  last_beat;
    logic                  out_fire;
    logic                  buf_load;

    assign last_beat = (3'(res_idx_reg) == res_cnt_reg - 3'd1);
    assign out_fire  = out_ch.valid && out_ch.ready;
    assign buf_free  = (res_cnt_reg == '0) || (last_beat && out_ch.ready);
    assign buf_load  = s3_fire && (n_vals != '0);

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        res_idx_next = res_idx_reg;
        if (buf_load)
        begin
            res_cnt_next = n_vals;
            res_idx_next = '0;
        end
        else if (out_fire)
        begin
            if (last_beat)
            begin
                res_cnt_next = '0;
                res_idx_next = '0;
            end
            else
            begin
                res_idx_next = res_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= '0;
            res_idx_reg <= '0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
            res_idx_reg <= res_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_load)
        begin
            res_reg      <= vals;
            res_done_reg <= s3_flags_reg.last_row && s3_flags_reg.last_col;
        end
    end

    assign out_ch.valid      = (res_cnt_reg != '0);
    assign out_ch.pixel_out  = bfx3_pkg::PIX_W'(res_reg[res_idx_reg]);
    assign out_ch.image_done = res_done_reg && last_beat;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // read pointer stays inside the loaded results
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_cnt_reg != '0) |-> (3'(res_idx_reg) < res_cnt_reg) && (res_cnt_reg <= 3'd4))
        else $error("output buffer index out of range");

    // the frame end always carries the full four-result flush
    a_done_full_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.image_done) |-> (res_cnt_reg == 3'd4))
        else $error("image_done without four results");

    // the reciprocal must leave a mean that fits the pixel width
    // only interior windows hold a sum made of written row memory entries
    a_mean_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_flags_reg.interior)
            |-> ((mean_prod >> (bfx3_pkg::DIV9_SHIFT + PIXEL_BITS)) == '0))
        else $error("mean overflows pixel width");

    // an accepted beat occupies stage 1 on the next cycle
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted beat lost before stage 1");

endmodule
